FILE: sv/gcra_pkg.sv
// ----------------------------------------------------------------------------
// gcra_pkg: shared types and constants of the rate limiter
// Widths, deny causes and the descriptor that travels from front to back.
// ----------------------------------------------------------------------------
package gcra_pkg;

	localparam int BUCKETS = 4096;
	localparam int IDX_W = $clog2(BUCKETS);
	localparam logic [31:0] NS_PER_SECOND = 32'd1000000000;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CAUSE_OK = 2'd0,
		CAUSE_OVER_LIMIT = 2'd1,
		CAUSE_COST_OVER_BURST = 2'd2,
		CAUSE_ZERO_RATE = 2'd3
	} cause_t;

	// Work descriptor produced by the front end.
	typedef struct packed {
		logic             charge;   // needs the bucket read-modify-write
		cause_t           cause;    // final cause when no charge is done
		logic [IDX_W-1:0] slot;
		logic [63:0]      now;
		logic [31:0]      period;
		logic [31:0]      burst;
		logic [31:0]      cost;
	} work_t;

	typedef struct packed {
		logic   allowed;
		cause_t cause;
	} result_t;

endpackage

FILE: sv/gcra_front.sv
// ----------------------------------------------------------------------------
// gcra_front: request intake and interval computation
// Accepts one request, classifies zero rate and cost over burst, and forms
// the ceiling of one second over the rate with a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module gcra_front import gcra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] bucket_index,
	input  logic [63:0] now_ns,
	input  logic [31:0] rate_per_second,
	input  logic [31:0] burst_limit,
	input  logic [31:0] cost_units,
	output logic        wvalid,
	input  logic        wready,
	output work_t       wdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

	state_t      state_q;
	work_t       work_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic [33:0] trial;
	logic [32:0] rem_sh;

	// Dividend is 1e9 + rate - 1; it fits in 33 bits, and its top bit seeds
	// the low bit of the remainder. The remainder always stays below the rate.
	assign rem_sh = {rem_q, quo_q[31]};
	assign trial = {1'b0, rem_sh} - {2'b0, work_q.period};

	assign full = (state_q != ST_IDLE);
	assign wvalid = (state_q == ST_OUT);
	assign wdata = work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			work_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						work_q.slot <= bucket_index[IDX_W-1:0];
						work_q.now <= now_ns;
						work_q.burst <= burst_limit;
						work_q.cost <= cost_units;
						// period holds the divisor while dividing
						work_q.period <= rate_per_second;
						if (rate_per_second == '0) begin
							work_q.charge <= 1'b0;
							work_q.cause <= CAUSE_ZERO_RATE;
							state_q <= ST_OUT;
						end else if (cost_units > burst_limit) begin
							work_q.charge <= 1'b0;
							work_q.cause <= CAUSE_COST_OVER_BURST;
							state_q <= ST_OUT;
						end else begin
							// 33-bit dividend: top bit seeds the remainder.
							{rem_q, quo_q} <= {31'd0, {1'b0, NS_PER_SECOND}
								+ {1'b0, rate_per_second} - 33'd1};
							work_q.charge <= 1'b1;
							work_q.cause <= CAUSE_OK;
							cnt_q <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (!trial[33]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (wready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DIV && cnt_q == 5'd31) begin
				work_q.period <= trial[33] ? {quo_q[30:0], 1'b0} : {quo_q[30:0], 1'b1};
			end
		end
	end

endmodule

FILE: sv/gcra_queue.sv
// ----------------------------------------------------------------------------
// gcra_queue: short descriptor queue between front and back
// A two-entry register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module gcra_queue import gcra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  work_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output work_t out_data
);

	work_t      mem_q [QDEPTH];
	logic [0:0] wptr_q;
	logic [0:0] rptr_q;
	logic [1:0] cnt_q;
	logic       do_w;
	logic       do_r;

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rptr_q];
	assign do_w = in_valid && in_ready;
	assign do_r = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_w) begin
			mem_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_w) wptr_q <= wptr_q + 1'b1;
			if (do_r) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, do_w} - {1'b0, do_r};
		end
	end

endmodule

FILE: sv/gcra_back.sv
// ----------------------------------------------------------------------------
// gcra_back: bucket update engine
// Reads the stored arrival time, forms the candidate and the allowance,
// writes back a conforming candidate and holds the result for the consumer.
// After reset a clearing pass zeroes one bucket per cycle over all BUCKETS
// entries, and no descriptor is taken until it is done.
// ----------------------------------------------------------------------------
module gcra_back import gcra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wvalid,
	output logic        wready,
	input  work_t       wdata,
	output logic        empty,
	input  logic        pop,
	output logic        allowed,
	output logic [1:0]  deny_cause
);

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_MUL, ST_CHECK, ST_OUT} state_t;

	state_t           state_q;
	work_t            work_q;
	logic [63:0]      mem_q [BUCKETS];
	logic [63:0]      rd_q;
	logic [63:0]      cand_q;
	logic [63:0]      allow_q;
	result_t          res_q;
	logic [63:0]      base;
	logic [63:0]      allow_prod;
	logic [63:0]      cost_prod;
	logic             clr_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             take;

	assign wready = (state_q == ST_IDLE) && !clr_q;
	assign take = wvalid && wready;
	assign empty = (state_q != ST_OUT);
	assign allowed = res_q.allowed;
	assign deny_cause = res_q.cause;
	assign base = (rd_q < work_q.now) ? work_q.now : rd_q;
	assign allow_prod = work_q.burst * work_q.period;
	assign cost_prod = work_q.cost * work_q.period;

	always_ff @(posedge clk) begin
		if (take) begin
			rd_q <= mem_q[wdata.slot];
		end
		if (clr_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (state_q == ST_CHECK && (cand_q - work_q.now) <= allow_q) begin
			mem_q[work_q.slot] <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q <= '0;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == IDX_W'(BUCKETS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						work_q <= wdata;
						if (wdata.charge) begin
							state_q <= ST_READ;
						end else begin
							res_q <= '{allowed: 1'b0, cause: wdata.cause};
							state_q <= ST_OUT;
						end
					end
				end
				ST_READ: begin
					allow_q <= allow_prod;
					cand_q <= cost_prod;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cand_q <= base + cand_q;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if ((cand_q - work_q.now) > allow_q) begin
						res_q <= '{allowed: 1'b0, cause: CAUSE_OVER_LIMIT};
					end else begin
						res_q <= '{allowed: 1'b1, cause: CAUSE_OK};
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/gcra_rate_limiter.sv
// ----------------------------------------------------------------------------
// gcra_rate_limiter: per-bucket rate limiter after the cell rate algorithm
// Front end divides for the interval, back end updates the bucket table.
// ----------------------------------------------------------------------------
// Channel   Handshake     Fields
// request   push / full   bucket_index, now_ns, rate_per_second, burst_limit,
//                         cost_units
// result    empty / pop   allowed, deny_cause
//
// A charging request passes the intake state, the serial interval divider
// and a hand-off state that waits on the queue; the front end takes no new
// request until the hand-off is done. The bucket engine then steps through
// ST_READ, ST_MUL and ST_CHECK. Zero rate and cost over burst skip the
// divider. The two-entry queue lets the divider start the next beat while
// the back end waits on pop. After reset the back end clears one bucket per
// cycle over all 4096 and takes no work until every bucket reads as zero.
// ----------------------------------------------------------------------------
module gcra_rate_limiter import gcra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] bucket_index,
	input  logic [63:0] now_ns,
	input  logic [31:0] rate_per_second,
	input  logic [31:0] burst_limit,
	input  logic [31:0] cost_units,
	output logic        empty,
	input  logic        pop,
	output logic        allowed,
	output logic [1:0]  deny_cause
);

	logic  f_valid;
	logic  f_ready;
	work_t f_data;
	logic  b_valid;
	logic  b_ready;
	work_t b_data;

	gcra_front u_front (
		.clk, .arst_n, .push, .full, .bucket_index, .now_ns,
		.rate_per_second, .burst_limit, .cost_units,
		.wvalid(f_valid), .wready(f_ready), .wdata(f_data)
	);

	gcra_queue u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	gcra_back u_back (
		.clk, .arst_n,
		.wvalid(b_valid), .wready(b_ready), .wdata(b_data),
		.empty, .pop, .allowed, .deny_cause
	);

endmodule
